// ===== rtl/lj_pkg.sv =====
// shared constants, register codes and saturation helper for the lj pair force pipeline
`timescale 1ns / 1ps
`default_nettype none
package lj_pkg;

  // default displacement width
  localparam int COORD_BITS_DEF = 20;

  // configuration register width and reset values
  localparam int CFG_W = 24;
  localparam logic [CFG_W-1:0] SIGMA_POW6_RST = 24'd840677;
  localparam logic [CFG_W-1:0] FOUR_EPS_RST   = 24'd570425;
  localparam logic [CFG_W-1:0] CUTOFF_SQ_RST  = 24'd1380719;

  // register bus
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = APB_AW - 2;
  localparam logic [REG_IDX_W-1:0] REG_SIGMA_POW6 = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FOUR_EPS   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CUTOFF_SQ  = 2'd2;

  // reciprocal divider geometry: divisor bits, quotient bits, bits per stage
  localparam int DIV_W    = 40;
  localparam int QUO_W    = 64;
  localparam int DIV_STEP = 2;

  // fixed point constants, Q32.32
  localparam logic [QUO_W-1:0] ONE_Q32   = 64'h0000_0001_0000_0000;
  localparam logic [QUO_W-1:0] SIX_LIMIT = 64'h2AAA_AAAA_AAAA_AAAA;

  // signed 32-bit saturation from sign and magnitude
  function automatic logic [31:0] sat32(input logic neg, input logic [QUO_W-1:0] mag);
    logic [31:0]      res;
    logic [QUO_W-1:0] twos;
    twos = ~mag + 64'd1;
    if (neg) begin
      if (mag >= 64'h8000_0000) res = 32'h8000_0000;
      else res = twos[31:0];
    end else begin
      if (mag > 64'h7FFF_FFFF) res = 32'h7FFF_FFFF;
      else res = mag[31:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lj_mul.sv =====
// two-stage 64x64 multiplier with fixed right shift and saturation to 64 bits
`timescale 1ns / 1ps
`default_nettype none
module lj_mul
  import lj_pkg::*;
#(
  parameter int SH = 32
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [QUO_W-1:0] a_i,
  input  logic [QUO_W-1:0] b_i,
  output logic [QUO_W-1:0] y_o
);

  localparam int HW = QUO_W / 2;

  logic [QUO_W-1:0]   ll_q, lh_q, hl_q, hh_q;
  logic [2*QUO_W-1:0] full;
  logic [QUO_W-1:0]   y_d, y_q;

  // stage one: four half-width partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= QUO_W'(a_i[HW-1:0])     * QUO_W'(b_i[HW-1:0]);
      lh_q <= QUO_W'(a_i[HW-1:0])     * QUO_W'(b_i[QUO_W-1:HW]);
      hl_q <= QUO_W'(a_i[QUO_W-1:HW]) * QUO_W'(b_i[HW-1:0]);
      hh_q <= QUO_W'(a_i[QUO_W-1:HW]) * QUO_W'(b_i[QUO_W-1:HW]);
    end
  end

  // stage two: combine, shift and saturate
  always_comb begin
    full = {hh_q, {QUO_W{1'b0}}}
         + {{HW{1'b0}}, lh_q, {HW{1'b0}}}
         + {{HW{1'b0}}, hl_q, {HW{1'b0}}}
         + {{QUO_W{1'b0}}, ll_q};
    if (full[2*QUO_W-1:QUO_W+SH] != '0) y_d = '1;
    else y_d = full[SH+QUO_W-1:SH];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q <= y_d;
    end
  end

  assign y_o = y_q;

endmodule
`default_nettype wire

// ===== rtl/lj_div.sv =====
// pipelined restoring divider forming floor((2^64-1)/den), a few quotient bits per stage
`timescale 1ns / 1ps
`default_nettype none
module lj_div
  import lj_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [DIV_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o
);

  localparam int N_STAGE = QUO_W / DIV_STEP;

  logic [DIV_W-1:0] den_q [N_STAGE];
  logic [DIV_W-1:0] rem_q [N_STAGE];
  logic [QUO_W-1:0] quo_q [N_STAGE];

  for (genvar g = 0; g < N_STAGE; g++) begin : g_stage
    logic [DIV_W-1:0] den_in;
    logic [DIV_W-1:0] rem_in;
    logic [QUO_W-1:0] quo_in;
    logic [DIV_W:0]   rem_t;
    logic [QUO_W-1:0] quo_t;

    // stage inputs
    if (g == 0) begin : g_first
      assign den_in = den_i;
      assign rem_in = '0;
      assign quo_in = '0;
    end else begin : g_next
      assign den_in = den_q[g-1];
      assign rem_in = rem_q[g-1];
      assign quo_in = quo_q[g-1];
    end

    // restoring steps, the dividend is all ones so a one is shifted in each step
    always_comb begin
      rem_t = {1'b0, rem_in};
      quo_t = quo_in;
      for (int k = 0; k < DIV_STEP; k++) begin
        rem_t = {rem_t[DIV_W-1:0], 1'b1};
        if (rem_t >= {1'b0, den_in}) begin
          rem_t = rem_t - {1'b0, den_in};
          quo_t = {quo_t[QUO_W-2:0], 1'b1};
        end else begin
          quo_t = {quo_t[QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[g] <= den_in;
        rem_q[g] <= rem_t[DIV_W-1:0];
        quo_q[g] <= quo_t;
      end
    end
  end

  assign quo_o = quo_q[N_STAGE-1];

endmodule
`default_nettype wire

// ===== rtl/lj_pair_force_core.sv =====
// top level of the lennard-jones 12-6 pair force pipeline
`timescale 1ns / 1ps
`default_nettype none
// Evaluates one atom pair per transaction: squared distance and cutoff test, a
// reciprocal of r2, then r6, the force on atom i, the half energy term, and the
// pair energy and virial term (halved for halo partners), all saturating Q16.16.
// The pipeline takes one pair every cycle while the output side does not stall.
// The reciprocal divider, 32 stages of 2 quotient bits each, is followed by a
// chain of seven two-stage 64x64 multipliers. A stall at the output freezes the
// whole pipeline. Configuration registers sit at byte addresses 0 (sigma_pow6),
// 4 (four_epsilon) and 8 (cutoff_sq) and must be written only while no
// transaction is in flight; the block itself does not enforce this.
module lj_pair_force_core
  import lj_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [APB_AW-1:0]            paddr,
  input  logic [APB_DW-1:0]            pwdata,
  output logic [APB_DW-1:0]            prdata,
  output logic                         pready,
  // pair input
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] delta_x_i,
  input  logic signed [COORD_BITS-1:0] delta_y_i,
  input  logic signed [COORD_BITS-1:0] delta_z_i,
  input  logic                         halo_partner_i,
  // result output
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [31:0]           force_x_o,
  output logic signed [31:0]           force_y_o,
  output logic signed [31:0]           force_z_o,
  output logic signed [31:0]           atom_energy_half_o,
  output logic signed [31:0]           pair_energy_o,
  output logic signed [31:0]           stress_term_o,
  output logic                         in_range_o
);

  localparam int SQ_W    = 2 * COORD_BITS;
  localparam int R2_W    = SQ_W + 2;
  localparam int CMP_W   = (R2_W > DIV_W) ? R2_W : DIV_W;
  localparam int DIV_LAT = QUO_W / DIV_STEP;

  // register stage positions counted from the input register
  localparam int P_DEN  = 3;
  localparam int P_IR2  = P_DEN + DIV_LAT;
  localparam int P_IR4  = P_IR2 + 2;
  localparam int P_R6   = P_IR4 + 2;
  localparam int P_S    = P_R6 + 2;
  localparam int P_E    = P_S + 1;
  localparam int P_M4   = P_E + 2;
  localparam int P_M5   = P_M4 + 2;
  localparam int P_Q6   = P_M5 + 1;
  localparam int P_FR   = P_Q6 + 2;
  localparam int P_LAST = P_FR + 2;

  // delay line lengths
  localparam int IR2_N = P_E - P_IR2;
  localparam int R6_N  = P_E - P_R6;
  localparam int SGN_N = P_LAST - P_S;
  localparam int HM_N  = P_M4 - P_S;
  localparam int E3_N  = P_LAST - P_M4;
  localparam int E4_N  = P_LAST - P_M5;

  typedef struct packed {
    logic [COORD_BITS-1:0] mag_x;
    logic [COORD_BITS-1:0] mag_y;
    logic [COORD_BITS-1:0] mag_z;
    logic                  neg_x;
    logic                  neg_y;
    logic                  neg_z;
    logic                  halo;
    logic                  hit;
    logic [SQ_W-1:0]       sq_x;
  } side_t;

  logic              adv;
  logic [CFG_W-1:0]  sigma_pow6_q, four_eps_q, cutoff_q;
  logic              cfg_wr;

  logic [P_LAST:1]   vld_q;
  side_t             side_q [1:P_LAST];
  side_t             side_in, side_s2, side_s3;
  logic [SQ_W-1:0]   sq_y_q, sq_z_q;
  logic [R2_W-1:0]   r2;
  logic [CMP_W-1:0]  r2_c, lim_c;
  logic              hit_d;
  logic [DIV_W-1:0]  den_d, den_q;

  logic [QUO_W-1:0]  ir2_div, ir4, r6, s_m;
  logic [QUO_W-1:0]  ir2_q [IR2_N];
  logic [QUO_W-1:0]  r6_q [R6_N];
  logic [QUO_W-1:0]  s_q, dmag_q, two_s, dmag_d, hmag_d;
  logic              dneg_d, hneg_d;
  logic              dneg_q [SGN_N];
  logic              hneg_q [SGN_N];
  logic [QUO_W-1:0]  hmag_q [HM_N];
  logic [QUO_W-1:0]  p_m, t_m, e3_m, q_m, e4_m, q6_q, fr_m;
  logic [QUO_W-1:0]  e3_q [E3_N];
  logic [QUO_W-1:0]  e4_q [E4_N];
  logic [QUO_W-1:0]  fx_m, fy_m, fz_m, e5_m;
  logic [QUO_W-1:0]  e4_h, e5_h;

  logic              out_valid_q;
  logic [31:0]       fx_q, fy_q, fz_q, eh_q, pe_q, st_q;
  logic              hit_q;

  // the whole pipeline moves unless a finished result waits at the output
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sigma_pow6_q <= SIGMA_POW6_RST;
      four_eps_q   <= FOUR_EPS_RST;
      cutoff_q     <= CUTOFF_SQ_RST;
    end else if (cfg_wr) begin
      unique case (paddr[APB_AW-1:2])
        REG_SIGMA_POW6: sigma_pow6_q <= pwdata[CFG_W-1:0];
        REG_FOUR_EPS:   four_eps_q   <= pwdata[CFG_W-1:0];
        REG_CUTOFF_SQ:  cutoff_q     <= pwdata[CFG_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[APB_AW-1:2])
      REG_SIGMA_POW6: prdata = APB_DW'(sigma_pow6_q);
      REG_FOUR_EPS:   prdata = APB_DW'(four_eps_q);
      REG_CUTOFF_SQ:  prdata = APB_DW'(cutoff_q);
      default:        prdata = '0;
    endcase
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[P_LAST-1:1], in_valid_i};
    end
  end

  // sign and magnitude of the displacement
  always_comb begin
    side_in       = '0;
    side_in.neg_x = delta_x_i[COORD_BITS-1];
    side_in.neg_y = delta_y_i[COORD_BITS-1];
    side_in.neg_z = delta_z_i[COORD_BITS-1];
    side_in.mag_x = side_in.neg_x ? COORD_BITS'(-delta_x_i) : COORD_BITS'(delta_x_i);
    side_in.mag_y = side_in.neg_y ? COORD_BITS'(-delta_y_i) : COORD_BITS'(delta_y_i);
    side_in.mag_z = side_in.neg_z ? COORD_BITS'(-delta_z_i) : COORD_BITS'(delta_z_i);
    side_in.halo  = halo_partner_i;
  end

  // squares, then r2 with the cutoff test and the divisor
  always_comb begin
    side_s2      = side_q[1];
    side_s2.sq_x = SQ_W'(side_q[1].mag_x) * SQ_W'(side_q[1].mag_x);
    r2     = R2_W'(side_q[2].sq_x) + R2_W'(sq_y_q) + R2_W'(sq_z_q);
    r2_c   = CMP_W'(r2);
    lim_c  = CMP_W'({cutoff_q, 16'h0000});
    hit_d  = r2_c <= lim_c;
    den_d  = (hit_d && r2_c != '0) ? r2_c[DIV_W-1:0] : DIV_W'(1);
    side_s3     = side_q[2];
    side_s3.hit = hit_d;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[1] <= side_in;
      side_q[2] <= side_s2;
      side_q[3] <= side_s3;
      for (int i = 4; i <= P_LAST; i++) side_q[i] <= side_q[i-1];
      sq_y_q <= SQ_W'(side_q[1].mag_y) * SQ_W'(side_q[1].mag_y);
      sq_z_q <= SQ_W'(side_q[1].mag_z) * SQ_W'(side_q[1].mag_z);
      den_q  <= den_d;
    end
  end

  // reciprocal of r2
  lj_div u_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .den_i (den_q),
    .quo_o (ir2_div)
  );

  // ir4 and r6
  lj_mul #(.SH(32)) u_mul_ir4 (
    .clk_i(clk_i), .en_i(adv), .a_i(ir2_div), .b_i(ir2_div), .y_o(ir4)
  );
  lj_mul #(.SH(32)) u_mul_r6 (
    .clk_i(clk_i), .en_i(adv), .a_i(ir4), .b_i(ir2_q[P_IR4-P_IR2-1]), .y_o(r6)
  );

  // s = sigma^6 * r6
  lj_mul #(.SH(16)) u_mul_s (
    .clk_i(clk_i), .en_i(adv), .a_i(QUO_W'(sigma_pow6_q)), .b_i(r6), .y_o(s_m)
  );

  // s - 1 and 2s - 1 as sign and magnitude
  always_comb begin
    dneg_d = s_m < ONE_Q32;
    dmag_d = dneg_d ? (ONE_Q32 - s_m) : (s_m - ONE_Q32);
    two_s  = s_m[QUO_W-1] ? '1 : {s_m[QUO_W-2:0], 1'b0};
    hneg_d = two_s < ONE_Q32;
    hmag_d = hneg_d ? (ONE_Q32 - two_s) : (two_s - ONE_Q32);
  end

  // delay lines for values used further down
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ir2_q[0] <= ir2_div;
      for (int i = 1; i < IR2_N; i++) ir2_q[i] <= ir2_q[i-1];
      r6_q[0] <= r6;
      for (int i = 1; i < R6_N; i++) r6_q[i] <= r6_q[i-1];
      s_q       <= s_m;
      dmag_q    <= dmag_d;
      dneg_q[0] <= dneg_d;
      hneg_q[0] <= hneg_d;
      for (int i = 1; i < SGN_N; i++) begin
        dneg_q[i] <= dneg_q[i-1];
        hneg_q[i] <= hneg_q[i-1];
      end
      hmag_q[0] <= hmag_d;
      for (int i = 1; i < HM_N; i++) hmag_q[i] <= hmag_q[i-1];
      e3_q[0] <= e3_m;
      for (int i = 1; i < E3_N; i++) e3_q[i] <= e3_q[i-1];
      e4_q[0] <= e4_m;
      for (int i = 1; i < E4_N; i++) e4_q[i] <= e4_q[i-1];
      q6_q <= (q_m > SIX_LIMIT) ? '1 : ({q_m[QUO_W-3:0], 2'b00} + {q_m[QUO_W-2:0], 1'b0});
    end
  end

  // s*ir2, s*(s-1) and the half energy term
  lj_mul #(.SH(32)) u_mul_p (
    .clk_i(clk_i), .en_i(adv), .a_i(s_q), .b_i(ir2_q[IR2_N-1]), .y_o(p_m)
  );
  lj_mul #(.SH(32)) u_mul_t (
    .clk_i(clk_i), .en_i(adv), .a_i(s_q), .b_i(dmag_q), .y_o(t_m)
  );
  lj_mul #(.SH(49)) u_mul_e3 (
    .clk_i(clk_i), .en_i(adv), .a_i(r6_q[R6_N-1]), .b_i(dmag_q), .y_o(e3_m)
  );

  // times (2s - 1), and the pair energy
  lj_mul #(.SH(32)) u_mul_q (
    .clk_i(clk_i), .en_i(adv), .a_i(p_m), .b_i(hmag_q[HM_N-1]), .y_o(q_m)
  );
  lj_mul #(.SH(40)) u_mul_e4 (
    .clk_i(clk_i), .en_i(adv), .a_i(QUO_W'(four_eps_q)), .b_i(t_m), .y_o(e4_m)
  );

  // force over r
  lj_mul #(.SH(24)) u_mul_fr (
    .clk_i(clk_i), .en_i(adv), .a_i(QUO_W'(four_eps_q)), .b_i(q6_q), .y_o(fr_m)
  );

  // force components and virial term
  lj_mul #(.SH(32)) u_mul_fx (
    .clk_i(clk_i), .en_i(adv), .a_i(QUO_W'(side_q[P_FR].mag_x)), .b_i(fr_m), .y_o(fx_m)
  );
  lj_mul #(.SH(32)) u_mul_fy (
    .clk_i(clk_i), .en_i(adv), .a_i(QUO_W'(side_q[P_FR].mag_y)), .b_i(fr_m), .y_o(fy_m)
  );
  lj_mul #(.SH(32)) u_mul_fz (
    .clk_i(clk_i), .en_i(adv), .a_i(QUO_W'(side_q[P_FR].mag_z)), .b_i(fr_m), .y_o(fz_m)
  );
  lj_mul #(.SH(48)) u_mul_e5 (
    .clk_i(clk_i), .en_i(adv), .a_i(QUO_W'(side_q[P_FR].sq_x)), .b_i(fr_m), .y_o(e5_m)
  );

  // halo partners halve the pair energy and the virial term
  assign e4_h = side_q[P_LAST].halo ? {1'b0, e4_q[E4_N-1][QUO_W-1:1]} : e4_q[E4_N-1];
  assign e5_h = side_q[P_LAST].halo ? {1'b0, e5_m[QUO_W-1:1]} : e5_m;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vld_q[P_LAST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_q <= side_q[P_LAST].hit;
      if (side_q[P_LAST].hit) begin
        fx_q <= sat32(side_q[P_LAST].neg_x ^ hneg_q[SGN_N-1], fx_m);
        fy_q <= sat32(side_q[P_LAST].neg_y ^ hneg_q[SGN_N-1], fy_m);
        fz_q <= sat32(side_q[P_LAST].neg_z ^ hneg_q[SGN_N-1], fz_m);
        eh_q <= sat32(dneg_q[SGN_N-1], e3_q[E3_N-1]);
        pe_q <= sat32(dneg_q[SGN_N-1], e4_h);
        st_q <= sat32(hneg_q[SGN_N-1], e5_h);
      end else begin
        fx_q <= '0;
        fy_q <= '0;
        fz_q <= '0;
        eh_q <= '0;
        pe_q <= '0;
        st_q <= '0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign force_x_o          = fx_q;
  assign force_y_o          = fy_q;
  assign force_z_o          = fz_q;
  assign atom_energy_half_o = eh_q;
  assign pair_energy_o      = pe_q;
  assign stress_term_o      = st_q;
  assign in_range_o         = hit_q;

  // out of range pairs come back as all zeros
  a_out_of_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_range_o |-> force_x_o == 0 && force_y_o == 0 && force_z_o == 0 &&
      atom_energy_half_o == 0 && pair_energy_o == 0 && stress_term_o == 0)
    else $error("out of range pair with nonzero result");

  // pair energy and half energy both take the sign of s-1, so a negative pair energy rules out a positive half energy
  a_energy_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pair_energy_o < 0 |-> atom_energy_half_o <= 0)
    else $error("energy terms disagree in sign");

  // 2s < 1 implies s < 1, so a negative virial term rules out positive energies
  a_virial_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stress_term_o < 0 |-> atom_energy_half_o <= 0 && pair_energy_o <= 0)
    else $error("virial sign inconsistent with energies");

endmodule
`default_nettype wire
